### sv/rwpg_pkg.sv
// Package of the rolling wave pixel generator: command and register codes,
// field widths and the request and response types of the shared divider.
// No dependencies.
`default_nettype none

package rwpg_pkg;

  localparam int CMD_W = 2;
  localparam int PIX_W = 16;
  localparam int SLOT_W = 4;
  localparam int COLOR_W = 24;
  localparam int CHAN_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int POS_W = 13;
  localparam int STEP_W = 9;
  localparam int PAL_MAX = 16;

  localparam int DIVIDEND_W = 17;
  localparam int DIVISOR_W = 13;
  localparam int DIV_CNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FILL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRAD_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRAIL_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_POWER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_COLOR = 3'd6;

  localparam logic [1:0] TRAIL_END = 2'd0;
  localparam logic [1:0] TRAIL_BOTH = 2'd1;
  localparam logic [1:0] TRAIL_LEAD = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quot;
    logic [DIVISOR_W-1:0]  rem;
  } div_rsp_t;

endpackage

`default_nettype wire

### sv/rwpg_in_if.sv
// Request channel of the rolling wave pixel generator.
// Depends on rwpg_pkg for the field widths.
`default_nettype none

interface rwpg_in_if;
  logic                          valid;
  logic                          ready;
  logic [rwpg_pkg::CMD_W-1:0]    cmd;
  logic [rwpg_pkg::PIX_W-1:0]    pixel_index;
  logic [rwpg_pkg::SLOT_W-1:0]   palette_slot;
  logic [rwpg_pkg::COLOR_W-1:0]  color_value;

  modport source (output valid, cmd, pixel_index, palette_slot, color_value, input ready);
  modport sink (input valid, cmd, pixel_index, palette_slot, color_value, output ready);
endinterface

`default_nettype wire

### sv/rwpg_out_if.sv
// Result channel of the rolling wave pixel generator: one RGB pixel per fill or tick request.
// Depends on rwpg_pkg for the field widths.
`default_nettype none

interface rwpg_out_if;
  logic                        valid;
  logic                        ready;
  logic [rwpg_pkg::CHAN_W-1:0] red;
  logic [rwpg_pkg::CHAN_W-1:0] green;
  logic [rwpg_pkg::CHAN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

### sv/rwpg_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on rwpg_pkg for the request and response types.
`default_nettype none

module rwpg_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rwpg_pkg::div_req_t req,
  output rwpg_pkg::div_rsp_t      rsp
);

  localparam int DW = rwpg_pkg::DIVIDEND_W;
  localparam int SW = rwpg_pkg::DIVISOR_W;
  localparam int CW = rwpg_pkg::DIV_CNT_W;

  logic [DW-1:0] quot_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [SW:0]   trial;
  logic          fits;
  logic [SW:0]   diff;
  logic [SW-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, quot_r[DW-1]};
    fits = trial >= {1'b0, dsr_r};
    diff = trial - {1'b0, dsr_r};
    rem_nxt = fits ? diff[SW-1:0] : trial[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[DW-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem = rem_r;

endmodule

`default_nettype wire

### sv/rolling_wave_pixel_generator.sv
// Rolling wave pixel generator: a palette load returns nothing; a fill request and a
// tick each use one shared 17-step restoring divider, which runs three times for a fill
// and four times for a tick (position modulo the cycle, wave index and step, trail
// dimming, and for a tick the position update); the palette memory read is registered
// between the wave index division and the trail dimming, and the pixel is formed last.
// One request is processed at a time; the finished pixel sits in an output register,
// so the next request is taken while it waits. Palette entries read before they are
// written return undefined colors.
`default_nettype none

module rolling_wave_pixel_generator #(
  parameter int PALETTE_DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  rwpg_in_if.sink                                  in_req,
  rwpg_out_if.source                               out_res,
  input  wire logic                                cfg_we,
  input  wire logic [rwpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rwpg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int PW = rwpg_pkg::POS_W;
  localparam int SW = rwpg_pkg::STEP_W;
  localparam int CW = rwpg_pkg::COLOR_W;
  localparam int DW = rwpg_pkg::DIVIDEND_W;
  localparam int VW = rwpg_pkg::DIVISOR_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOD_T = 7'b0000010,
    S_DIV_L = 7'b0000100,
    S_RD    = 7'b0001000,
    S_DIM   = 7'b0010000,
    S_POS   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  logic [7:0]  grad_r;
  logic [7:0]  spacing_r;
  logic [1:0]  trail_r;
  logic [4:0]  plen_r;
  logic [15:0] leds_r;
  logic [7:0]  dim_r;
  logic [CW-1:0] bg_color_r;

  state_t state_r, state_nxt;
  logic [rwpg_pkg::CMD_W-1:0] cmd_r;
  logic [SW-1:0] step_r, step_nxt;
  logic          pick_r, pick_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] cwc_r, cwc_nxt;
  logic [7:0]    ratio_r, ratio_nxt;
  logic [CW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          out_valid_r;
  logic [7:0]    out_red_r, out_green_r, out_blue_r;
  logic          out_load;

  logic [CW-1:0] pal_mem [PALETTE_DEPTH];

  rwpg_pkg::div_req_t div_req;
  rwpg_pkg::div_rsp_t div_rsp;

  logic [7:0]  g_eff;
  logic [4:0]  plen_eff;
  logic [SW-1:0] wave_len;
  logic [13:0] t_prod;
  logic [PW-1:0] t_len;
  logic [15:0] far_idx;
  logic        in_acc;

  logic [7:0] half, first, mid;
  logic       adj;
  logic [9:0] st_w;
  logic [7:0] st;
  logic [15:0] prod;
  logic       is_bg, is_head;
  logic [16:0] sc_r, sc_g, sc_b;
  logic [CW-1:0] pix_color;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_r <= 8'd8;
      spacing_r <= 8'd0;
      trail_r <= rwpg_pkg::TRAIL_BOTH;
      plen_r <= 5'd1;
      leds_r <= 16'd1;
      dim_r <= 8'd255;
      bg_color_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rwpg_pkg::REG_GRAD_LENGTH:      grad_r <= cfg_data[7:0];
        rwpg_pkg::REG_SPACING:          spacing_r <= cfg_data[7:0];
        rwpg_pkg::REG_TRAIL_MODE:       trail_r <= cfg_data[1:0];
        rwpg_pkg::REG_PALETTE_LENGTH:   plen_r <= cfg_data[4:0];
        rwpg_pkg::REG_LED_COUNT:        leds_r <= cfg_data[15:0];
        rwpg_pkg::REG_DIM_POWER:        dim_r <= cfg_data[7:0];
        rwpg_pkg::REG_BACKGROUND_COLOR: bg_color_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Cycle geometry.
  always_comb begin
    g_eff = (grad_r == 8'd0) ? 8'd1 : grad_r;
    plen_eff = plen_r;
    if (plen_eff == 5'd0) plen_eff = 5'd1;
    if (plen_eff > 5'(rwpg_pkg::PAL_MAX)) plen_eff = 5'(rwpg_pkg::PAL_MAX);
    if (32'(plen_eff) > PALETTE_DEPTH) plen_eff = 5'(PALETTE_DEPTH);
    wave_len = {1'b0, g_eff} + {1'b0, spacing_r};
    t_prod = {9'd0, plen_eff} * {5'd0, wave_len};
    t_len = t_prod[PW-1:0];
    far_idx = leds_r - 16'd1;
  end

  // Trail shape for the current step.
  always_comb begin
    case (trail_r)
      rwpg_pkg::TRAIL_END: begin
        half = g_eff;
        first = 8'd0;
        adj = 1'b0;
        mid = 8'd0;
      end
      rwpg_pkg::TRAIL_LEAD: begin
        half = g_eff;
        first = g_eff;
        adj = 1'b0;
        mid = g_eff - 8'd1;
      end
      default: begin
        half = {1'b0, g_eff[7:1]};
        first = {1'b0, g_eff[7:1]};
        adj = g_eff[0];
        mid = {1'b0, g_eff[7:1]};
      end
    endcase
    if (step_r < {1'b0, first}) begin
      st_w = {2'b0, half} - {1'b0, step_r};
    end else if (step_r < {1'b0, g_eff}) begin
      st_w = {2'b0, half} + {9'd0, adj} + {1'b0, step_r} - {2'b0, g_eff};
    end else begin
      st_w = '0;
    end
    st = st_w[7:0];
    prod = st * dim_r;
    is_bg = step_r >= {1'b0, g_eff};
    is_head = step_r == {1'b0, mid};
  end

  // Pixel color from the registered dimming ratio.
  always_comb begin
    sc_r = cwc_r[23:16] * ({1'b0, ratio_r} + 9'd1);
    sc_g = cwc_r[15:8] * ({1'b0, ratio_r} + 9'd1);
    sc_b = cwc_r[7:0] * ({1'b0, ratio_r} + 9'd1);
    if (is_bg) begin
      pix_color = bg_color_r;
    end else if (is_head) begin
      pix_color = cwc_r;
    end else begin
      pix_color = {sc_r[15:8], sc_g[15:8], sc_b[15:8]};
    end
  end

  assign in_acc = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_res.ready);
  assign rd_addr = AW'(div_rsp.quot[3:0]);

  // Palette memory.
  always_ff @(posedge clk) begin
    if (in_acc && (in_req.cmd == rwpg_pkg::CMD_LOAD) &&
        (32'(in_req.palette_slot) < PALETTE_DEPTH)) begin
      pal_mem[AW'(in_req.palette_slot)] <= in_req.color_value;
    end
    rd_data_r <= pal_mem[rd_addr];
  end

  rwpg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    pick_nxt = pick_r;
    wp_nxt = wp_r;
    cwc_nxt = cwc_r;
    ratio_nxt = ratio_r;
    div_req.start = 1'b0;
    div_req.dividend = '0;
    div_req.divisor = t_len;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_req.cmd == rwpg_pkg::CMD_FILL)) begin
          div_req.start = 1'b1;
          div_req.dividend = DW'(in_req.pixel_index);
          state_nxt = S_MOD_T;
        end else if (in_acc && (in_req.cmd == rwpg_pkg::CMD_TICK)) begin
          div_req.start = 1'b1;
          div_req.dividend = DW'(wp_r) + DW'(far_idx);
          state_nxt = S_MOD_T;
        end
      end
      S_MOD_T: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.dividend = DW'(div_rsp.rem);
          div_req.divisor = VW'(wave_len);
          state_nxt = S_DIV_L;
        end
      end
      S_DIV_L: begin
        if (div_rsp.done) begin
          step_nxt = div_rsp.rem[SW-1:0];
          pick_nxt = (cmd_r == rwpg_pkg::CMD_FILL) || (div_rsp.rem == '0);
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (pick_r) cwc_nxt = rd_data_r;
        if (cmd_r == rwpg_pkg::CMD_FILL) begin
          wp_nxt = (step_r + 9'd1 == wave_len) ? '0 : PW'(step_r + 9'd1);
        end
        div_req.start = 1'b1;
        div_req.dividend = DW'(prod);
        div_req.divisor = VW'({1'b0, half} + 9'd1);
        state_nxt = S_DIM;
      end
      S_DIM: begin
        if (div_rsp.done) begin
          ratio_nxt = dim_r - div_rsp.quot[7:0];
          if (cmd_r == rwpg_pkg::CMD_TICK) begin
            div_req.start = 1'b1;
            div_req.dividend = DW'(wp_r) + DW'(1);
            state_nxt = S_POS;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_POS: begin
        if (div_rsp.done) begin
          wp_nxt = div_rsp.rem;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r <= '0;
      cwc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r <= wp_nxt;
      cwc_r <= cwc_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) cmd_r <= in_req.cmd;
    step_r <= step_nxt;
    pick_r <= pick_nxt;
    ratio_r <= ratio_nxt;
    if (out_load) begin
      out_red_r <= pix_color[23:16];
      out_green_r <= pix_color[15:8];
      out_blue_r <= pix_color[7:0];
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.red = out_red_r;
  assign out_res.green = out_green_r;
  assign out_res.blue = out_blue_r;

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_MOD_T || state_r == S_DIV_L ||
                      state_r == S_DIM || state_r == S_POS))
    else $error("divider finished outside a waiting state");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while idle");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("finished pixel not presented");

  a_work_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_req.cmd == rwpg_pkg::CMD_FILL || in_req.cmd == rwpg_pkg::CMD_TICK))
      |=> (state_r == S_MOD_T && div_rsp.busy))
    else $error("pixel request did not start the divider");

endmodule

`default_nettype wire

### sim/rwpg_pixel_checker.sv
// Pixel checker for the rolling wave pixel generator: watches the request, result and
// register write ports, keeps its own copy of the wave state and compares each pixel.
// Depends on rwpg_pkg and the rwpg_in_if and rwpg_out_if interfaces.
`default_nettype none

module rwpg_pixel_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  rwpg_in_if                                   in_ch,
  rwpg_out_if                                  out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [rwpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rwpg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                   failures,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]                   grad_len_q;
  logic [7:0]                   spacing_q;
  logic [1:0]                   trail_q;
  logic [4:0]                   plen_q;
  logic [15:0]                  led_q;
  logic [7:0]                   dim_q;
  logic [rwpg_pkg::COLOR_W-1:0] bg_q;

  logic [rwpg_pkg::POS_W-1:0]   wave_pos;
  logic [rwpg_pkg::COLOR_W-1:0] wave_rgb;
  logic [rwpg_pkg::COLOR_W-1:0] palette [rwpg_pkg::PAL_MAX];

  logic [rwpg_pkg::COLOR_W-1:0] pixels_due [$];
  int                           fail_count = 0;

  function automatic int unsigned grad_eff();
    return (grad_len_q == 8'd0) ? 1 : int'(grad_len_q);
  endfunction

  function automatic int unsigned palette_count();
    int unsigned n;
    n = plen_q;
    if (n == 0) n = 1;
    if (n > rwpg_pkg::PAL_MAX) n = rwpg_pkg::PAL_MAX;
    return n;
  endfunction

  function automatic int unsigned wave_span();
    return grad_eff() + int'(spacing_q);
  endfunction

  function automatic int unsigned cycle_span();
    return palette_count() * wave_span();
  endfunction

  function automatic void pick_wave(int unsigned pos);
    wave_rgb = palette[(pos % cycle_span()) / wave_span()];
  endfunction

  function automatic logic [7:0] scale_chan(logic [7:0] c, int unsigned ratio);
    int unsigned prod;
    prod = (int'(c) * (ratio + 1)) >> 8;
    return prod[7:0];
  endfunction

  // Trail pixels fade linearly toward the ends of the wave; the head keeps full color.
  function automatic logic [rwpg_pkg::COLOR_W-1:0] shade_pixel(int unsigned step);
    int unsigned g, half, first, adj, mid, st, dim, ratio;
    g = grad_eff();
    dim = dim_q;
    if (trail_q == rwpg_pkg::TRAIL_END) begin
      half = g; first = 0; adj = 0; mid = 0;
    end else if (trail_q == rwpg_pkg::TRAIL_LEAD) begin
      half = g; first = g; adj = 0; mid = g - 1;
    end else begin
      half = g / 2; first = half; adj = g & 1; mid = half;
    end
    if (step < first) begin
      st = half - step;
    end else if (step < g) begin
      st = half + adj + step - g;
    end else begin
      return bg_q;
    end
    if (step == mid) return wave_rgb;
    ratio = (dim - (st * dim) / (half + 1)) & 32'hFF;
    return {scale_chan(wave_rgb[23:16], ratio), scale_chan(wave_rgb[15:8], ratio),
            scale_chan(wave_rgb[7:0], ratio)};
  endfunction

  function automatic void apply_write(logic [rwpg_pkg::CFG_IDX_W-1:0] idx,
                                      logic [rwpg_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      rwpg_pkg::REG_GRAD_LENGTH: begin
        grad_len_q = data[7:0];
      end
      rwpg_pkg::REG_SPACING: begin
        spacing_q = data[7:0];
      end
      rwpg_pkg::REG_TRAIL_MODE: begin
        trail_q = data[1:0];
      end
      rwpg_pkg::REG_PALETTE_LENGTH: begin
        plen_q = data[4:0];
      end
      rwpg_pkg::REG_LED_COUNT: begin
        led_q = data[15:0];
      end
      rwpg_pkg::REG_DIM_POWER: begin
        dim_q = data[7:0];
      end
      rwpg_pkg::REG_BACKGROUND_COLOR: begin
        bg_q = data[rwpg_pkg::COLOR_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void take_request(logic [rwpg_pkg::CMD_W-1:0] cmd,
                                       logic [rwpg_pkg::PIX_W-1:0] pix,
                                       logic [rwpg_pkg::SLOT_W-1:0] slot,
                                       logic [rwpg_pkg::COLOR_W-1:0] rgb);
    int unsigned len, step, far, pos;
    len = wave_span();
    case (cmd)
      rwpg_pkg::CMD_LOAD: begin
        palette[slot] = rgb;
      end
      rwpg_pkg::CMD_FILL: begin
        pos = pix;
        step = pos % len;
        pick_wave(pos - step);
        pixels_due.push_back(shade_pixel(step));
        wave_pos = rwpg_pkg::POS_W'((pos + 1) % len);
      end
      rwpg_pkg::CMD_TICK: begin
        far = (int'(led_q) + 32'hFFFF) & 32'hFFFF;
        pos = int'(wave_pos) + far;
        step = pos % len;
        if (step == 0) pick_wave(pos);
        pixels_due.push_back(shade_pixel(step));
        wave_pos = rwpg_pkg::POS_W'((int'(wave_pos) + 1) % cycle_span());
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    logic [rwpg_pkg::COLOR_W-1:0] want;
    if (!rst_n) begin
      grad_len_q = 8'd8;
      spacing_q = 8'd0;
      trail_q = rwpg_pkg::TRAIL_BOTH;
      plen_q = 5'd1;
      led_q = 16'd1;
      dim_q = 8'd255;
      bg_q = '0;
      wave_pos = '0;
      wave_rgb = '0;
      pixels_due.delete();
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (out_ch.valid && out_ch.ready) begin
        if (pixels_due.size() == 0) begin
          $error("pixel result arrived with no request waiting for it");
          fail_count++;
        end else begin
          want = pixels_due.pop_front();
          if (out_ch.red !== want[23:16]) begin
            $error("red: expected %0d, got %0d", want[23:16], out_ch.red);
            fail_count++;
          end
          if (out_ch.green !== want[15:8]) begin
            $error("green: expected %0d, got %0d", want[15:8], out_ch.green);
            fail_count++;
          end
          if (out_ch.blue !== want[7:0]) begin
            $error("blue: expected %0d, got %0d", want[7:0], out_ch.blue);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        take_request(in_ch.cmd, in_ch.pixel_index, in_ch.palette_slot, in_ch.color_value);
      end
    end
    failures <= fail_count;
    pending <= pixels_due.size();
  end

endmodule

`default_nettype wire

### sim/tb_rolling_wave_pixel_generator.sv
// Testbench top of the rolling wave pixel generator: clock, reset, register settings,
// bursty requests and a stalling receiver; rwpg_pixel_checker does all the checking.
// Depends on rwpg_pkg, the channel interfaces, the block and the pixel checker.
`default_nettype none

module tb_rolling_wave_pixel_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 150;
  localparam int PHASES = 14;
  localparam int ITEMS_PER_PHASE = 92;

  localparam logic [rwpg_pkg::CMD_W-1:0]     CMD_SPARE = 2'd3;
  localparam logic [rwpg_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [1:0]                     TRAIL_SPARE = 2'd3;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SLOW} rx_style_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [rwpg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rwpg_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              failures;
  int                              pending;
  int                              burst_left = 0;
  int                              cycle_count = 0;

  rwpg_in_if  in_ch ();
  rwpg_out_if out_ch ();

  rolling_wave_pixel_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rwpg_pixel_checker pixel_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : receiver
    rx_style_t   style;
    int unsigned span;
    int unsigned beat;
    out_ch.ready <= 1'b0;
    beat = 0;
    forever begin
      style = rx_style_t'($urandom_range(0, 3));
      span = $urandom_range(50, 400);
      repeat (span) begin
        @(posedge clk);
        beat++;
        case (style)
          RX_OPEN: begin
            out_ch.ready <= 1'b1;
          end
          RX_RANDOM: begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
          end
          RX_PERIODIC: begin
            out_ch.ready <= ((beat % 7) >= 3);
          end
          default: begin
            out_ch.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  task automatic push_request(logic [rwpg_pkg::CMD_W-1:0] cmd,
                              logic [rwpg_pkg::PIX_W-1:0] pix,
                              logic [rwpg_pkg::SLOT_W-1:0] slot,
                              logic [rwpg_pkg::COLOR_W-1:0] rgb);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.pixel_index <= pix;
    in_ch.palette_slot <= slot;
    in_ch.color_value <= rgb;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  task automatic push_random_request();
    logic [rwpg_pkg::CMD_W-1:0] cmd;
    logic [rwpg_pkg::PIX_W-1:0] pix;
    int unsigned                roll;
    roll = $urandom_range(0, 99);
    if (roll < 68) cmd = rwpg_pkg::CMD_TICK;
    else if (roll < 88) cmd = rwpg_pkg::CMD_FILL;
    else if (roll < 97) cmd = rwpg_pkg::CMD_LOAD;
    else cmd = CMD_SPARE;
    pix = ($urandom_range(0, 1) != 0) ? rwpg_pkg::PIX_W'($urandom)
                                       : rwpg_pkg::PIX_W'($urandom_range(0, 1100));
    push_request(cmd, pix, rwpg_pkg::SLOT_W'($urandom), rwpg_pkg::COLOR_W'($urandom));
  endtask

  // Lets the block run dry so that registers can be changed safely.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [rwpg_pkg::CFG_IDX_W-1:0] idx,
                           logic [rwpg_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [7:0] grad, logic [7:0] gap_px, logic [1:0] trail,
                               logic [4:0] plen, logic [15:0] leds, logic [7:0] dim,
                               logic [rwpg_pkg::COLOR_W-1:0] bg);
    write_reg(rwpg_pkg::REG_GRAD_LENGTH, rwpg_pkg::CFG_DATA_W'(grad));
    write_reg(rwpg_pkg::REG_SPACING, rwpg_pkg::CFG_DATA_W'(gap_px));
    write_reg(rwpg_pkg::REG_TRAIL_MODE, rwpg_pkg::CFG_DATA_W'(trail));
    write_reg(rwpg_pkg::REG_PALETTE_LENGTH, rwpg_pkg::CFG_DATA_W'(plen));
    write_reg(rwpg_pkg::REG_LED_COUNT, rwpg_pkg::CFG_DATA_W'(leds));
    write_reg(rwpg_pkg::REG_DIM_POWER, rwpg_pkg::CFG_DATA_W'(dim));
    write_reg(rwpg_pkg::REG_BACKGROUND_COLOR, rwpg_pkg::CFG_DATA_W'(bg));
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [rwpg_pkg::COLOR_W-1:0] rgb;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= rwpg_pkg::CMD_LOAD;
    in_ch.pixel_index <= '0;
    in_ch.palette_slot <= '0;
    in_ch.color_value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every palette entry is loaded before any wave can read it.
    for (int s = 0; s < rwpg_pkg::PAL_MAX; s++) begin
      if (s < 2) rgb = {rwpg_pkg::COLOR_W{s == 0}};
      else if (s < 5) rgb = rwpg_pkg::COLOR_W'(32'hFF << (8 * (4 - s)));
      else rgb = rwpg_pkg::COLOR_W'($urandom);
      push_request(rwpg_pkg::CMD_LOAD, rwpg_pkg::PIX_W'($urandom),
                   rwpg_pkg::SLOT_W'(s), rgb);
    end
    push_request(rwpg_pkg::CMD_FILL, 16'd0, rwpg_pkg::SLOT_W'($urandom),
                 rwpg_pkg::COLOR_W'($urandom));
    push_request(rwpg_pkg::CMD_FILL, 16'hFFFF, rwpg_pkg::SLOT_W'($urandom),
                 rwpg_pkg::COLOR_W'($urandom));
    push_request(rwpg_pkg::CMD_FILL, 16'd7, rwpg_pkg::SLOT_W'($urandom),
                 rwpg_pkg::COLOR_W'($urandom));
    repeat (3) push_request(rwpg_pkg::CMD_TICK, rwpg_pkg::PIX_W'($urandom),
                            rwpg_pkg::SLOT_W'($urandom), rwpg_pkg::COLOR_W'($urandom));
    push_request(CMD_SPARE, rwpg_pkg::PIX_W'($urandom), rwpg_pkg::SLOT_W'($urandom),
                 rwpg_pkg::COLOR_W'($urandom));
    push_request(rwpg_pkg::CMD_LOAD, rwpg_pkg::PIX_W'($urandom), 4'd15, 24'h5A5AA5);
    push_request(rwpg_pkg::CMD_TICK, rwpg_pkg::PIX_W'($urandom),
                 rwpg_pkg::SLOT_W'($urandom), rwpg_pkg::COLOR_W'($urandom));
    push_request(rwpg_pkg::CMD_FILL, 16'd4, rwpg_pkg::SLOT_W'($urandom),
                 rwpg_pkg::COLOR_W'($urandom));
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 6) write_reg(REG_SPARE, rwpg_pkg::CFG_DATA_W'($urandom));
      case (phase)
        0: begin
          apply_setting(8'd0, 8'd0, rwpg_pkg::TRAIL_END, 5'd0, 16'd0, 8'd0, 24'h000000);
        end
        1: begin
          apply_setting(8'd255, 8'd255, rwpg_pkg::TRAIL_LEAD, 5'd16, 16'hFFFF, 8'd255,
                        24'hFFFFFF);
        end
        2: begin
          apply_setting(8'd1, 8'd1, TRAIL_SPARE, 5'd31, 16'd1, 8'd128,
                        rwpg_pkg::COLOR_W'($urandom));
        end
        3: begin
          apply_setting(8'd2, 8'd0, rwpg_pkg::TRAIL_BOTH, 5'd17, 16'd2, 8'd200,
                        rwpg_pkg::COLOR_W'($urandom));
        end
        4: begin
          apply_setting(8'd7, 8'd3, rwpg_pkg::TRAIL_BOTH, 5'd5, 16'd40, 8'd255,
                        rwpg_pkg::COLOR_W'($urandom));
        end
        5: begin
          apply_setting(8'd8, 8'd0, rwpg_pkg::TRAIL_BOTH, 5'd1, 16'd1, 8'd255, 24'h000000);
        end
        default: begin
          apply_setting(
            ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 20)) : 8'($urandom),
            ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 6)) : 8'($urandom),
            2'($urandom),
            5'($urandom),
            ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 300)) : 16'($urandom),
            8'($urandom),
            rwpg_pkg::COLOR_W'($urandom));
        end
      endcase
      repeat (ITEMS_PER_PHASE) push_random_request();
      settle();
    end

    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
